/* hw/rtl/dlts_pkg.sv */
// dlts_pkg: shared types and codes for the delta list task scheduler
// no dependencies
package dlts_pkg;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_ADD      = 2'd1,
    OP_DELETE   = 2'd2,
    OP_DISPATCH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_DEL_EMPTY = 2'd2,
    ST_NOT_DUE   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_FULL       = 2'd1,
    ERR_DEL_EMPTY  = 2'd2,
    ERR_EMPTY_HEAD = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_LEFT_SUB,
    CELL_RIGHT,
    CELL_MERGE,
    CELL_TICK
  } cell_cmd_e;

  typedef struct packed {
    logic        valid;
    logic        due;
    logic [31:0] delta;
    logic [31:0] period;
  } entry_t;

endpackage

/* hw/rtl/dlts_list_cell.sv */
// dlts_list_cell: one position of the sorted delta list
// depends on dlts_pkg
module dlts_list_cell #(
  parameter int SLOT_W = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dlts_pkg::cell_cmd_e cmd_i,
  input  dlts_pkg::entry_t    left_entry_i,
  input  logic [SLOT_W-1:0]   left_slot_i,
  input  dlts_pkg::entry_t    right_entry_i,
  input  logic [SLOT_W-1:0]   right_slot_i,
  input  logic [SLOT_W-1:0]   new_slot_i,
  input  logic [31:0]         new_delta_i,
  input  logic [31:0]         new_period_i,
  output dlts_pkg::entry_t    entry_o,
  output logic [SLOT_W-1:0]   slot_o
);
  import dlts_pkg::*;

  entry_t            entry_q, entry_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [31:0]       sum;
  logic [31:0]       dec;

  always_comb begin
    entry_d = entry_q;
    slot_d  = slot_q;
    sum     = right_entry_i.delta + entry_q.delta;
    dec     = (entry_q.delta != 32'd0) ? entry_q.delta - 32'd1 : entry_q.delta;
    unique case (cmd_i)
      CELL_HOLD: ;
      CELL_LOAD: begin
        entry_d.valid  = 1'b1;
        entry_d.due    = 1'b0;
        entry_d.delta  = new_delta_i;
        entry_d.period = new_period_i;
        slot_d         = new_slot_i;
      end
      CELL_LEFT: begin
        entry_d = left_entry_i;
        slot_d  = left_slot_i;
      end
      CELL_LEFT_SUB: begin
        entry_d       = left_entry_i;
        entry_d.delta = left_entry_i.delta - new_delta_i;
        slot_d        = left_slot_i;
      end
      CELL_RIGHT: begin
        entry_d = right_entry_i;
        slot_d  = right_slot_i;
      end
      CELL_MERGE: begin
        entry_d       = right_entry_i;
        entry_d.delta = sum;
        entry_d.due   = (sum != 32'd0) ? 1'b0 : right_entry_i.due;
        slot_d        = right_slot_i;
      end
      CELL_TICK: begin
        entry_d.delta = dec;
        if (dec == 32'd0) entry_d.due = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      slot_q  <= '0;
    end else begin
      entry_q <= entry_d;
      slot_q  <= slot_d;
    end
  end

  assign entry_o = entry_q;
  assign slot_o  = slot_q;

endmodule

/* hw/rtl/dlts_free_stack.sv */
// dlts_free_stack: row of slot cells holding free slot numbers, top first
// no package dependencies
module dlts_free_stack #(
  parameter int N      = 16,
  parameter int SLOT_W = 4,
  parameter int CNT_W  = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_i,
  input  logic              push_i,
  input  logic [SLOT_W-1:0] push_slot_i,
  output logic [SLOT_W-1:0] top_o,
  output logic              empty_o,
  output logic [CNT_W-1:0]  count_o
);

  logic [SLOT_W-1:0] slot_q [N];
  logic [CNT_W-1:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) slot_q[i] <= SLOT_W'(i);
      count_q <= CNT_W'(N);
    end else if (pop_i) begin
      for (int i = 0; i < N - 1; i++) slot_q[i] <= slot_q[i+1];
      count_q <= count_q - CNT_W'(1);
    end else if (push_i) begin
      for (int i = 1; i < N; i++) slot_q[i] <= slot_q[i-1];
      slot_q[0] <= push_slot_i;
      count_q   <= count_q + CNT_W'(1);
    end
  end

  assign top_o   = slot_q[0];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

/* hw/rtl/delta_list_task_scheduler_unit.sv */
// delta_list_task_scheduler_unit: timer queue as a row of list cells plus a free slot stack
// depends on dlts_pkg, dlts_list_cell, dlts_free_stack
//
//  channel | signals                                             | dir
//  in      | in_valid_i, in_stall_o, operation_i, start_delay_i, | in
//          | repeat_period_i, target_slot_i                      |
//  out     | out_valid_o, out_stall_i, status_o, slot_o,         | out
//          | run_task_o, last_error_o                            |
//
// tick, delete, one-shot dispatch and every refused request go from S_IDLE straight to S_RESP
// add and periodic dispatch first walk the cell row in S_WALK, one position a cycle,
// until the insert position is found, and load the new entry there
// one item in flight; in_stall_o is high until its result has entered the output register
// reset empties the list and loads the free stack with slots 0 upward
module delta_list_task_scheduler_unit #(
  parameter int MAX_TASKS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [31:0] start_delay_i,
  input  logic [31:0] repeat_period_i,
  input  logic [3:0] target_slot_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [3:0] slot_o,
  output logic       run_task_o,
  output logic [1:0] last_error_o
);
  import dlts_pkg::*;

  localparam int N      = MAX_TASKS;
  localparam int SLOT_W = $clog2(N);
  localparam int CNT_W  = $clog2(N + 1);
  localparam int CMP_W  = SLOT_W + 4;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] k_q, k_d;
  logic [31:0]       r_q, r_d;
  logic [31:0]       per_q, per_d;
  logic [SLOT_W-1:0] ins_slot_q, ins_slot_d;
  status_e           res_status_q, res_status_d;
  logic [3:0]        res_slot_q, res_slot_d;
  logic              res_run_q, res_run_d;
  err_e              err_q, err_d;
  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [3:0]        out_slot_q;
  logic              out_run_q;
  logic [1:0]        out_err_q;

  entry_t            cell_entry [N];
  logic [SLOT_W-1:0] cell_slot  [N];
  cell_cmd_e         cmd        [N];

  logic              pop, push;
  logic [SLOT_W-1:0] push_slot, free_top;
  logic              free_empty;
  logic [CNT_W-1:0]  free_count;

  logic              accept;
  logic              pre;
  logic              any_match;
  logic [SLOT_W-1:0] match_slot;
  logic [N-1:0]      match;
  logic [N-1:0]      valid_vec;
  logic              due_bad;
  entry_t            walk_e;
  logic              walk_ins;
  logic              res_take;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign res_take = !out_valid_q || !out_stall_i;

  always_comb begin
    any_match  = 1'b0;
    match_slot = '0;
    due_bad    = 1'b0;
    walk_e     = '0;
    for (int i = 0; i < N; i++) begin
      valid_vec[i] = cell_entry[i].valid;
      match[i] = cell_entry[i].valid &&
                 (CMP_W'(cell_slot[i]) == CMP_W'(target_slot_i));
      any_match = any_match | match[i];
      if (match[i]) match_slot = match_slot | cell_slot[i];
      if (cell_entry[i].due && cell_entry[i].delta != 32'd0) due_bad = 1'b1;
      if (k_q == SLOT_W'(i)) walk_e = cell_entry[i];
    end
    walk_ins = !walk_e.valid || (walk_e.delta > r_q);
  end

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    r_d          = r_q;
    per_d        = per_q;
    ins_slot_d   = ins_slot_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_run_d    = res_run_q;
    err_d        = err_q;
    pop          = 1'b0;
    push         = 1'b0;
    push_slot    = '0;
    pre          = 1'b0;
    for (int i = 0; i < N; i++) cmd[i] = CELL_HOLD;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = ST_OK;
          res_slot_d   = 4'd0;
          res_run_d    = 1'b0;
          state_d      = S_RESP;
          unique case (op_e'(operation_i))
            OP_TICK: begin
              if (cell_entry[0].valid) cmd[0] = CELL_TICK;
            end
            OP_ADD: begin
              if (free_empty) begin
                res_status_d = ST_FULL;
                err_d        = ERR_FULL;
              end else begin
                pop        = 1'b1;
                ins_slot_d = free_top;
                r_d        = start_delay_i;
                per_d      = repeat_period_i;
                k_d        = '0;
                res_slot_d = 4'(free_top);
                state_d    = S_WALK;
              end
            end
            OP_DELETE: begin
              if (!cell_entry[0].valid) begin
                res_status_d = ST_DEL_EMPTY;
                err_d        = ERR_DEL_EMPTY;
              end else begin
                for (int i = 0; i < N; i++) begin
                  if (match[i]) cmd[i] = CELL_MERGE;
                  else if (pre) cmd[i] = CELL_RIGHT;
                  pre = pre | match[i];
                end
                push      = any_match;
                push_slot = match_slot;
              end
            end
            OP_DISPATCH: begin
              if (!cell_entry[0].valid || !cell_entry[0].due) begin
                res_status_d = ST_NOT_DUE;
              end else begin
                res_run_d  = 1'b1;
                res_slot_d = 4'(cell_slot[0]);
                for (int i = 0; i < N; i++) cmd[i] = CELL_RIGHT;
                if (cell_entry[0].period == 32'd0) begin
                  push      = 1'b1;
                  push_slot = cell_slot[0];
                end else begin
                  ins_slot_d = cell_slot[0];
                  r_d        = cell_entry[0].period;
                  per_d      = cell_entry[0].period;
                  k_d        = '0;
                  state_d    = S_WALK;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (walk_ins) begin
          for (int i = 0; i < N; i++) begin
            if (SLOT_W'(i) == k_q) cmd[i] = CELL_LOAD;
            else if ((SLOT_W + 1)'(i) == {1'b0, k_q} + (SLOT_W + 1)'(1))
              cmd[i] = CELL_LEFT_SUB;
            else if ((SLOT_W + 1)'(i) > {1'b0, k_q}) cmd[i] = CELL_LEFT;
          end
          state_d = S_RESP;
        end else begin
          r_d = r_q - walk_e.delta;
          k_d = k_q + SLOT_W'(1);
        end
      end
      S_RESP: begin
        if (res_take) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    entry_t            le, re;
    logic [SLOT_W-1:0] ls, rs;
    if (g == 0) begin : g_first
      assign le = '0;
      assign ls = '0;
    end else begin : g_mid
      assign le = cell_entry[g-1];
      assign ls = cell_slot[g-1];
    end
    if (g == N - 1) begin : g_last
      assign re = '0;
      assign rs = '0;
    end else begin : g_inner
      assign re = cell_entry[g+1];
      assign rs = cell_slot[g+1];
    end
    dlts_list_cell #(.SLOT_W(SLOT_W)) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd[g]),
      .left_entry_i  (le),
      .left_slot_i   (ls),
      .right_entry_i (re),
      .right_slot_i  (rs),
      .new_slot_i    (ins_slot_q),
      .new_delta_i   (r_q),
      .new_period_i  (per_q),
      .entry_o       (cell_entry[g]),
      .slot_o        (cell_slot[g])
    );
  end

  dlts_free_stack #(.N(N), .SLOT_W(SLOT_W), .CNT_W(CNT_W)) u_free (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (pop),
    .push_i      (push),
    .push_slot_i (push_slot),
    .top_o       (free_top),
    .empty_o     (free_empty),
    .count_o     (free_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
      if (state_q == S_RESP && res_take) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    r_q          <= r_d;
    per_q        <= per_d;
    ins_slot_q   <= ins_slot_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_run_q    <= res_run_d;
    if (state_q == S_RESP && res_take) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_run_q    <= res_run_q;
      out_err_q    <= err_q;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign slot_o       = out_slot_q;
  assign run_task_o   = out_run_q;
  assign last_error_o = out_err_q;

  a_slot_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) || (CNT_W + 1)'($countones(valid_vec)) + (CNT_W + 1)'(free_count)
      == (CNT_W + 1)'(N))
    else $error("slots lost or duplicated between list and free stack");

  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("hole in list cell row");

  a_due_zero: assert property (@(posedge clk_i) disable iff (!rst_ni) !due_bad)
    else $error("due task with nonzero delta");

  a_walk_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> !cell_entry[N-1].valid)
    else $error("insert walk with full list row");

endmodule
